FILE: hdl/brc_pkg.sv
// Shared types and constants for the box region classifier.
`default_nettype none

package brc_pkg;

   // Operation codes carried on req_operation.
   typedef enum logic [1:0] {
      OP_ADD      = 2'd0,
      OP_CLASSIFY = 2'd1,
      OP_NAMED    = 2'd2,
      OP_CLEAR    = 2'd3
   } brc_op_type;

   // Width of the rsp_area_number field.
   localparam int AREA_NUM_BITS = 2;

   // Default key loaded at reset.
   localparam logic [31:0] DEFAULT_KEY_RESET = 32'd2072609373;

   // Control part of the token walking down the cell chain.
   typedef struct packed {
      logic valid;
      logic hit;
   } brc_flag_type;

endpackage

`default_nettype wire

FILE: hdl/brc_cell.sv
// One chain cell: holds one box and tests the passing query token against it.
`default_nettype none

module brc_cell #(
   parameter int INDEX      = 0,
   parameter int COORD_BITS = 24,
   parameter int BCW        = 7,
   parameter int ACW        = 3
) (
   input  wire                          clock,
   input  wire                          reset,
   // box write, broadcast to all cells
   input  wire                          wr_en,
   input  wire signed [COORD_BITS-1:0]  wr_low_x,
   input  wire signed [COORD_BITS-1:0]  wr_low_y,
   input  wire signed [COORD_BITS-1:0]  wr_high_x,
   input  wire signed [COORD_BITS-1:0]  wr_high_y,
   input  wire        [ACW-1:0]         wr_owner,
   input  wire        [BCW-1:0]         box_count,
   // token from the left neighbor
   input  brc_pkg::brc_flag_type        in_flag,
   input  wire signed [COORD_BITS-1:0]  in_px,
   input  wire signed [COORD_BITS-1:0]  in_py,
   input  wire        [ACW-1:0]         in_best,
   input  wire        [ACW-1:0]         in_target,
   // token to the right neighbor
   output brc_pkg::brc_flag_type        out_flag,
   output logic signed [COORD_BITS-1:0] out_px,
   output logic signed [COORD_BITS-1:0] out_py,
   output logic       [ACW-1:0]         out_best,
   output logic       [ACW-1:0]         out_target
);

   logic signed [COORD_BITS-1:0] low_x_ff, low_y_ff, high_x_ff, high_y_ff;
   logic        [ACW-1:0]        owner_ff;
   brc_pkg::brc_flag_type        flag_ff, flag_in;
   logic signed [COORD_BITS-1:0] px_ff, py_ff;
   logic        [ACW-1:0]        best_ff, best_in, target_ff;
   logic                         active, holds;

   // only cells below the fill count hold a box
   assign active = BCW'(INDEX) < box_count;
   assign holds  = active && (in_px >= low_x_ff) && (in_px <= high_x_ff) &&
                   (in_py >= low_y_ff) && (in_py <= high_y_ff);

   always_comb begin
      flag_in       = in_flag;
      best_in       = in_best;
      if (holds && (owner_ff < in_best)) begin
         best_in = owner_ff;
      end
      if (holds && (owner_ff == in_target)) begin
         flag_in.hit = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && (box_count == BCW'(INDEX))) begin
         low_x_ff  <= wr_low_x;
         low_y_ff  <= wr_low_y;
         high_x_ff <= wr_high_x;
         high_y_ff <= wr_high_y;
         owner_ff  <= wr_owner;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff <= '0;
      end else begin
         flag_ff <= flag_in;
      end
      px_ff     <= in_px;
      py_ff     <= in_py;
      best_ff   <= best_in;
      target_ff <= in_target;
   end

   assign out_flag   = flag_ff;
   assign out_px     = px_ff;
   assign out_py     = py_ff;
   assign out_best   = best_ff;
   assign out_target = target_ff;

endmodule

`default_nettype wire

FILE: hdl/brc_area_table.sv
// Area key table: append, clear, registered key match and key readback.
`default_nettype none

module brc_area_table #(
   parameter int MAX_AREAS = 4,
   parameter int AW        = 2,
   parameter int ACW       = 3
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              look_en,
   input  wire  [31:0]      look_key,
   input  wire              add_en,
   input  wire  [31:0]      add_key,
   input  wire              clear,
   input  wire  [AW-1:0]    rd_idx,
   output logic [31:0]      rd_key,
   output logic             hit,
   output logic [ACW-1:0]   idx,
   output logic [ACW-1:0]   count
);

   logic [31:0]          keys_ff [MAX_AREAS];
   logic [ACW-1:0]       count_ff, count_in;
   logic [MAX_AREAS-1:0] match_ff, match_in;

   always_comb begin
      for (int a = 0; a < MAX_AREAS; a++) begin
         match_in[a] = (ACW'(a) < count_ff) && (keys_ff[a] == look_key);
      end
   end

   // lowest matching entry
   always_comb begin
      idx = '0;
      for (int a = MAX_AREAS - 1; a >= 0; a--) begin
         if (match_ff[a]) begin
            idx = ACW'(a);
         end
      end
   end

   assign hit = |match_ff;

   always_comb begin
      count_in = count_ff;
      if (clear) begin
         count_in = '0;
      end else if (add_en) begin
         count_in = count_ff + ACW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      if (look_en) begin
         match_ff <= match_in;
      end
      if (add_en && !clear) begin
         keys_ff[count_ff[AW-1:0]] <= add_key;
      end
   end

   assign rd_key = keys_ff[rd_idx];
   assign count  = count_ff;

endmodule

`default_nettype wire

FILE: hdl/box_region_classifier_core.sv
// Top level of the box region classifier: control, area table and box cell chain.
`default_nettype none

// Keeps up to MAX_BOXES axis-aligned rectangles, each owned by one of up to MAX_AREAS
// areas numbered in order of first appearance of their 32-bit key. Operations: add box,
// classify point (lowest containing area, else csr default key), test point in a named
// area, and clear the tables. One item is in flight at a time. The key is matched
// against the area table at the input transfer edge. The next cycle decodes the
// operation, and the finish state moves the result into the output register once the
// slot is free. Add, clear and a named test with an unknown key go there directly.
// Classify and named test send a token down a chain of MAX_BOXES cells, one box per
// cell and one cell per cycle; the sequencer waits in the walk state until it leaves.
// The input stalls from its transfer until the result is loaded, and a stalled result
// that holds the output register keeps the input stalled. The next input transfer is
// taken while a result waits in that register. The default key is written through the
// csr port, which is always ready; write it only while idle.
module box_region_classifier_core #(
   parameter int MAX_BOXES  = 64,
   parameter int MAX_AREAS  = 4,
   parameter int COORD_BITS = 24
) (
   input  wire                          clock,
   input  wire                          reset,
   // input channel
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire  [1:0]                   req_operation,
   input  wire  signed [COORD_BITS-1:0] req_point_x,
   input  wire  signed [COORD_BITS-1:0] req_point_y,
   input  wire  signed [COORD_BITS-1:0] req_corner_x,
   input  wire  signed [COORD_BITS-1:0] req_corner_y,
   input  wire  [31:0]                  req_area_key,
   // result channel
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic                         rsp_found,
   output logic [brc_pkg::AREA_NUM_BITS-1:0] rsp_area_number,
   output logic [31:0]                  rsp_result_key,
   output logic                         rsp_in_named,
   output logic                         rsp_unknown_area,
   output logic                         rsp_table_full,
   // configuration channel
   input  wire                          csr_valid,
   output logic                         csr_ready,
   input  wire  [31:0]                  csr_data
);

   localparam int BCW = $clog2(MAX_BOXES + 1);
   localparam int ACW = $clog2(MAX_AREAS + 1);
   localparam int AW  = (MAX_AREAS > 1) ? $clog2(MAX_AREAS) : 1;
   localparam int ANB = brc_pkg::AREA_NUM_BITS;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_LOOKUP = 4'b0010,
      S_WALK   = 4'b0100,
      S_FINISH = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic                         req_xfer, slot_free;
   brc_pkg::brc_op_type          op_ff;
   logic signed [COORD_BITS-1:0] px_ff, py_ff, cx_ff, cy_ff;
   logic [31:0]                  key_ff;
   logic [31:0]                  default_key_ff;
   logic [BCW-1:0]               box_count_ff, box_count_in;

   // pending result, moved to the output register when the slot is free
   logic             pend_found_ff, pend_found_in;
   logic [ANB-1:0]   pend_num_ff, pend_num_in;
   logic [31:0]      pend_key_ff, pend_key_in;
   logic             pend_named_ff, pend_named_in;
   logic             pend_unknown_ff, pend_unknown_in;
   logic             pend_full_ff, pend_full_in;

   logic             rsp_valid_ff;
   logic             rsp_found_ff, rsp_named_ff, rsp_unknown_ff, rsp_full_ff;
   logic [ANB-1:0]   rsp_num_ff;
   logic [31:0]      rsp_key_ff;

   // area table
   logic             area_add, area_clear, area_hit;
   logic [ACW-1:0]   area_idx, area_count;
   logic [31:0]      area_rd_key;

   // box write and chain
   logic                         box_wr;
   logic signed [COORD_BITS-1:0] wr_low_x, wr_low_y, wr_high_x, wr_high_y;
   logic                         launch;
   logic                         tail_found;
   logic [ACW+ANB-1:0]           tail_best_wide;

   brc_pkg::brc_flag_type        flag_chain   [MAX_BOXES + 1];
   logic signed [COORD_BITS-1:0] px_chain     [MAX_BOXES + 1];
   logic signed [COORD_BITS-1:0] py_chain     [MAX_BOXES + 1];
   logic [ACW-1:0]               best_chain   [MAX_BOXES + 1];
   logic [ACW-1:0]               target_chain [MAX_BOXES + 1];

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   // corners ordered per axis
   assign wr_low_x  = (px_ff < cx_ff) ? px_ff : cx_ff;
   assign wr_high_x = (px_ff < cx_ff) ? cx_ff : px_ff;
   assign wr_low_y  = (py_ff < cy_ff) ? py_ff : cy_ff;
   assign wr_high_y = (py_ff < cy_ff) ? cy_ff : py_ff;

   brc_area_table #(
      .MAX_AREAS (MAX_AREAS),
      .AW        (AW),
      .ACW       (ACW)
   ) u_area_table (
      .clock    (clock),
      .reset    (reset),
      .look_en  (req_xfer),
      .look_key (req_area_key),
      .add_en   (area_add),
      .add_key  (key_ff),
      .clear    (area_clear),
      .rd_idx   (best_chain[MAX_BOXES][AW-1:0]),
      .rd_key   (area_rd_key),
      .hit      (area_hit),
      .idx      (area_idx),
      .count    (area_count)
   );

   // token enters at the head of the chain; best starts at the area count
   assign flag_chain[0]   = '{valid: launch, hit: 1'b0};
   assign px_chain[0]     = px_ff;
   assign py_chain[0]     = py_ff;
   assign best_chain[0]   = area_count;
   assign target_chain[0] = area_idx;

   for (genvar i = 0; i < MAX_BOXES; i++) begin : g_cell
      brc_cell #(
         .INDEX      (i),
         .COORD_BITS (COORD_BITS),
         .BCW        (BCW),
         .ACW        (ACW)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .wr_en      (box_wr),
         .wr_low_x   (wr_low_x),
         .wr_low_y   (wr_low_y),
         .wr_high_x  (wr_high_x),
         .wr_high_y  (wr_high_y),
         .wr_owner   (area_hit ? area_idx : area_count),
         .box_count  (box_count_ff),
         .in_flag    (flag_chain[i]),
         .in_px      (px_chain[i]),
         .in_py      (py_chain[i]),
         .in_best    (best_chain[i]),
         .in_target  (target_chain[i]),
         .out_flag   (flag_chain[i+1]),
         .out_px     (px_chain[i+1]),
         .out_py     (py_chain[i+1]),
         .out_best   (best_chain[i+1]),
         .out_target (target_chain[i+1])
      );
   end

   assign tail_found     = best_chain[MAX_BOXES] < area_count;
   assign tail_best_wide = {{ANB{1'b0}}, best_chain[MAX_BOXES]};

   // sequencer
   always_comb begin
      state_in        = state_ff;
      box_count_in    = box_count_ff;
      box_wr          = 1'b0;
      area_add        = 1'b0;
      area_clear      = 1'b0;
      launch          = 1'b0;
      pend_found_in   = pend_found_ff;
      pend_num_in     = pend_num_ff;
      pend_key_in     = pend_key_ff;
      pend_named_in   = pend_named_ff;
      pend_unknown_in = pend_unknown_ff;
      pend_full_in    = pend_full_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               state_in = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            pend_found_in   = 1'b0;
            pend_num_in     = '0;
            pend_key_in     = '0;
            pend_named_in   = 1'b0;
            pend_unknown_in = 1'b0;
            pend_full_in    = 1'b0;
            state_in        = S_FINISH;
            case (op_ff)
               brc_pkg::OP_ADD: begin
                  if ((box_count_ff == BCW'(MAX_BOXES)) ||
                      (!area_hit && (area_count == ACW'(MAX_AREAS)))) begin
                     pend_full_in = 1'b1;
                  end else begin
                     box_wr       = 1'b1;
                     area_add     = !area_hit;
                     box_count_in = box_count_ff + BCW'(1);
                  end
               end
               brc_pkg::OP_CLASSIFY: begin
                  launch   = 1'b1;
                  state_in = S_WALK;
               end
               brc_pkg::OP_NAMED: begin
                  if (area_hit) begin
                     launch   = 1'b1;
                     state_in = S_WALK;
                  end else begin
                     pend_unknown_in = 1'b1;
                  end
               end
               brc_pkg::OP_CLEAR: begin
                  area_clear   = 1'b1;
                  box_count_in = '0;
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         S_WALK: begin
            if (flag_chain[MAX_BOXES].valid) begin
               state_in = S_FINISH;
               if (op_ff == brc_pkg::OP_CLASSIFY) begin
                  pend_found_in = tail_found;
                  pend_num_in   = tail_found ? tail_best_wide[ANB-1:0] : '0;
                  pend_key_in   = tail_found ? area_rd_key : default_key_ff;
               end else begin
                  pend_named_in = flag_chain[MAX_BOXES].hit;
               end
            end
         end
         S_FINISH: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         box_count_ff   <= '0;
         default_key_ff <= brc_pkg::DEFAULT_KEY_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         box_count_ff <= box_count_in;
         if (csr_valid && csr_ready) begin
            default_key_ff <= csr_data;
         end
         if ((state_ff == S_FINISH) && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         op_ff  <= brc_pkg::brc_op_type'(req_operation);
         px_ff  <= req_point_x;
         py_ff  <= req_point_y;
         cx_ff  <= req_corner_x;
         cy_ff  <= req_corner_y;
         key_ff <= req_area_key;
      end
      pend_found_ff   <= pend_found_in;
      pend_num_ff     <= pend_num_in;
      pend_key_ff     <= pend_key_in;
      pend_named_ff   <= pend_named_in;
      pend_unknown_ff <= pend_unknown_in;
      pend_full_ff    <= pend_full_in;
      if ((state_ff == S_FINISH) && slot_free) begin
         rsp_found_ff   <= pend_found_ff;
         rsp_num_ff     <= pend_num_ff;
         rsp_key_ff     <= pend_key_ff;
         rsp_named_ff   <= pend_named_ff;
         rsp_unknown_ff <= pend_unknown_ff;
         rsp_full_ff    <= pend_full_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_area_number  = rsp_num_ff;
   assign rsp_result_key   = rsp_key_ff;
   assign rsp_in_named     = rsp_named_ff;
   assign rsp_unknown_area = rsp_unknown_ff;
   assign rsp_table_full   = rsp_full_ff;

`ifndef NO_ASSERTIONS
   // a token leaves the chain only while the sequencer waits for it
   a_tail_in_walk: assert property (@(posedge clock) disable iff (reset)
      flag_chain[MAX_BOXES].valid |-> (state_ff == S_WALK))
      else $error("chain token arrived outside walk");

   // the box fill count never passes the table size
   a_box_count: assert property (@(posedge clock) disable iff (reset)
      box_count_ff <= BCW'(MAX_BOXES))
      else $error("box count overflow");

   // an input transfer always moves on to the key lookup
   a_xfer_lookup: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff == S_LOOKUP))
      else $error("input transfer not followed by lookup");

   // a classify hit never carries add or named-test flags
   a_found_excl: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |-> (!rsp_table_full && !rsp_unknown_area && !rsp_in_named))
      else $error("found result carries foreign flags");
`endif

endmodule

`default_nettype wire
